// File: rtl/core/amus_pkg.sv
// ----------------------------------------------------------------------------
// amus_pkg
// Shared types and constants of the acknowledged message sender.
// ----------------------------------------------------------------------------
package amus_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [7:0] START_RST   = 8'hA5;
    localparam logic [7:0] ACK_RST     = 8'hF9;
    localparam logic [7:0] TIMEOUT_RST = 8'd10;

    // input tuser: action in [1:0], rx_error in [2]
    localparam int IN_USER_W = 3;

    // fixed part of the result word: tx_valid, tx_byte, accepted, error_flag
    localparam int OUT_FIXED_W = 11;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch request data, clear result fields
        logic store_byte;   // write text byte at fill position
        logic set_overlong;
        logic clr_fill;
        logic commit;       // write terminator and length, queue the message
        logic start_tx;
        logic clr_wait;
        logic count_tick;
        logic dequeue;
        logic read_byte;    // read message byte, advance position
        logic load_byte;    // present byte read on the previous cycle
        logic set_error;
        logic load_out;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic ack_match;
        logic fill_full;
        logic fill_overlong;
        logic below_slots;
        logic below_slots_m1;
        logic queue_busy;
        logic pos_lt_len;
        logic pos_at_end;
        logic tick_expired;
    } t_dp_stat;

endpackage

// File: rtl/core/acked_message_uart_sender.sv
// Sequencing: an accepted request passes S_EXEC and then S_DONE, with S_TERM between
//   them for a commit, S_LEN for a dequeue and S_READ for a message byte read.
// Requests: the sequencer handles one request at a time and takes the next
//   once the result is loaded; S_DONE waits while the result output is stalled.
// Reset: synchronous, active low; queue, link phase, timers, error flag and
//   config registers reset at once, message memories are not cleared.
// ----------------------------------------------------------------------------
// acked_message_uart_sender
// Queues text messages and sends them over a byte link with acknowledges.
// ----------------------------------------------------------------------------
module acked_message_uart_sender #(
    parameter int MSG_SLOTS = 64,
    parameter int MSG_BYTES = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,  // [7:0] data
    input  logic [amus_pkg::IN_USER_W-1:0] i_s_tuser,  // [1:0] action, [2] rx_error
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] accepted, [10] error_flag,
    // [10+CW:11] queue_count, zero fill above
    output logic [((amus_pkg::OUT_FIXED_W + $clog2(MSG_SLOTS + 1) + 7) / 8) * 8 - 1:0]
                                           o_m_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [amus_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    localparam int OUT_W = ((amus_pkg::OUT_FIXED_W + $clog2(MSG_SLOTS + 1) + 7) / 8) * 8;

    amus_pkg::t_dp_cmd  cmd;
    amus_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    amus_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (i_s_tuser[1:0]),
        .i_last     (i_s_tlast),
        .i_rx_error (i_s_tuser[2]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    amus_datapath #(
        .MSG_SLOTS (MSG_SLOTS),
        .MSG_BYTES (MSG_BYTES),
        .OUT_W     (OUT_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_data      (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_m_tdata)
    );

endmodule

// File: rtl/core/amus_datapath.sv
// ----------------------------------------------------------------------------
// amus_datapath
// Message store, length table, queue pointers, timers, config and result regs.
// ----------------------------------------------------------------------------
module amus_datapath #(
    parameter int MSG_SLOTS = 64,
    parameter int MSG_BYTES = 256,
    parameter int OUT_W     = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  amus_pkg::t_dp_cmd             i_cmd,
    output amus_pkg::t_dp_stat            o_stat,
    input  logic [7:0]                    i_data,
    input  logic                          i_cfg_we,
    input  logic [amus_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    output logic [OUT_W-1:0]              o_out_data
);

    localparam int SW    = $clog2(MSG_SLOTS);
    localparam int FW    = $clog2(MSG_BYTES);
    localparam int LW    = $clog2(MSG_BYTES + 1);
    localparam int CW    = $clog2(MSG_SLOTS + 1);
    localparam int DEPTH = MSG_SLOTS * MSG_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]    r_store [DEPTH];
    logic [LW-1:0] r_len_mem [MSG_SLOTS];

    logic [7:0]    r_start, r_ack, r_timeout;
    logic [7:0]    r_data;
    logic [SW-1:0] r_head, r_send_slot;
    logic [CW-1:0] r_waiting;
    logic [FW-1:0] r_fill_len;
    logic          r_overlong;
    logic [LW-1:0] r_pos, r_send_len;
    logic [7:0]    r_wait_ticks;
    logic          r_error;
    logic          r_tx_valid, r_accepted;
    logic [7:0]    r_tx_byte, r_rd_byte;
    logic [OUT_W-1:0] r_out_data;

    logic [CW:0]      slot_sum;
    logic [SW-1:0]    fill_slot, head_next;
    logic [AW-1:0]    fill_addr, send_addr;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic [OUT_W-1:0] n_out_data;

    // tail of the ring: head + count, wrapped once
    assign slot_sum  = (CW + 1)'(r_head) + (CW + 1)'(r_waiting);
    assign fill_slot = (slot_sum >= (CW + 1)'(MSG_SLOTS))
                     ? SW'(slot_sum - (CW + 1)'(MSG_SLOTS)) : SW'(slot_sum);
    assign head_next = (r_head == SW'(MSG_SLOTS - 1)) ? '0 : r_head + SW'(1);

    assign fill_addr = AW'(fill_slot) * AW'(MSG_BYTES) + AW'(r_fill_len);
    assign send_addr = AW'(r_send_slot) * AW'(MSG_BYTES) + AW'(r_pos);

    assign wr_en   = i_cmd.store_byte | i_cmd.commit;
    assign wr_data = i_cmd.commit ? 8'h00 : r_data;

    always_comb begin
        o_stat.ack_match      = (r_data == r_ack);
        o_stat.fill_full      = (r_fill_len >= FW'(MSG_BYTES - 1));
        o_stat.fill_overlong  = r_overlong;
        o_stat.below_slots    = (r_waiting < CW'(MSG_SLOTS));
        o_stat.below_slots_m1 = (r_waiting < CW'(MSG_SLOTS - 1));
        o_stat.queue_busy     = (r_waiting != '0);
        o_stat.pos_lt_len     = (r_pos < r_send_len);
        o_stat.pos_at_end     = ((LW + 1)'(r_pos) + (LW + 1)'(1)) >= (LW + 1)'(r_send_len);
        o_stat.tick_expired   = (r_wait_ticks >= r_timeout);
    end

    always_comb begin
        n_out_data           = '0;
        n_out_data[0]        = r_tx_valid;
        n_out_data[8:1]      = r_tx_byte;
        n_out_data[9]        = r_accepted;
        n_out_data[10]       = r_error;
        n_out_data[amus_pkg::OUT_FIXED_W +: CW] = r_waiting;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[fill_addr] <= wr_data;
        end
        if (i_cmd.read_byte) begin
            r_rd_byte <= r_store[send_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_len_mem[fill_slot] <= LW'(r_fill_len) + LW'(1);
        end
        r_send_len <= r_len_mem[r_send_slot];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_data     <= i_data;
            r_tx_valid <= 1'b0;
            r_tx_byte  <= 8'h00;
            r_accepted <= 1'b0;
        end else begin
            if (i_cmd.start_tx) begin
                r_tx_valid <= 1'b1;
                r_tx_byte  <= r_start;
            end else if (i_cmd.load_byte) begin
                r_tx_valid <= 1'b1;
                r_tx_byte  <= r_rd_byte;
            end
            if (i_cmd.commit) begin
                r_accepted <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out_data <= n_out_data;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= amus_pkg::START_RST;
            r_ack        <= amus_pkg::ACK_RST;
            r_timeout    <= amus_pkg::TIMEOUT_RST;
            r_head       <= '0;
            r_waiting    <= '0;
            r_fill_len   <= '0;
            r_overlong   <= 1'b0;
            r_send_slot  <= '0;
            r_pos        <= '0;
            r_wait_ticks <= '0;
            r_error      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    amus_pkg::CFG_START:   r_start   <= i_cfg_data;
                    amus_pkg::CFG_ACK:     r_ack     <= i_cfg_data;
                    amus_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.clr_fill) begin
                r_fill_len <= '0;
                r_overlong <= 1'b0;
            end else begin
                if (i_cmd.store_byte) begin
                    r_fill_len <= r_fill_len + FW'(1);
                end
                if (i_cmd.set_overlong) begin
                    r_overlong <= 1'b1;
                end
            end

            if (i_cmd.commit) begin
                r_waiting <= r_waiting + CW'(1);
            end else if (i_cmd.dequeue) begin
                r_waiting <= r_waiting - CW'(1);
            end

            if (i_cmd.dequeue) begin
                r_send_slot <= r_head;
                r_head      <= head_next;
                r_pos       <= '0;
            end else if (i_cmd.read_byte) begin
                r_pos <= r_pos + LW'(1);
            end

            if (i_cmd.clr_wait) begin
                r_wait_ticks <= '0;
            end else if (i_cmd.count_tick && r_wait_ticks != 8'hFF) begin
                r_wait_ticks <= r_wait_ticks + 8'd1;
            end

            if (i_cmd.set_error) begin
                r_error <= 1'b1;
            end
        end
    end

    assign o_out_data = r_out_data;

endmodule

// File: rtl/core/amus_ctrl.sv
// ----------------------------------------------------------------------------
// amus_ctrl
// Request sequencer, link phase machine and stream handshakes.
// ----------------------------------------------------------------------------
module amus_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [1:0]         i_action,
    input  logic               i_last,
    input  logic               i_rx_error,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output amus_pkg::t_dp_cmd  o_cmd,
    input  amus_pkg::t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        ACT_ENQUEUE  = 2'd0,
        ACT_TX_READY = 2'd1,
        ACT_RX_BYTE  = 2'd2,
        ACT_TICK     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_START,
        PH_SENDING,
        PH_WAIT_MSG
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TERM,
        S_LEN,
        S_READ,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_phase  r_phase, n_phase;
    t_action r_action;
    logic    r_last, r_rx_error;
    logic    r_in_ready, r_out_valid;
    logic    accept, out_free, slot_free;

    assign accept    = i_s_tvalid & r_in_ready;
    assign out_free  = ~r_out_valid | i_m_tready;
    // the slot under transmission stays reserved
    assign slot_free = (r_phase == PH_SENDING) ? i_stat.below_slots_m1 : i_stat.below_slots;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_action)
                    ACT_ENQUEUE: begin
                        if (i_stat.fill_full || !slot_free) begin
                            o_cmd.set_overlong = ~r_last;
                        end else begin
                            o_cmd.store_byte = 1'b1;
                        end
                        if (r_last) begin
                            if (!i_stat.fill_overlong && !i_stat.fill_full && slot_free) begin
                                n_state = S_TERM;
                            end else begin
                                o_cmd.clr_fill = 1'b1;
                            end
                        end
                    end
                    ACT_TX_READY: begin
                        if (r_phase == PH_IDLE && i_stat.queue_busy) begin
                            o_cmd.start_tx = 1'b1;
                            o_cmd.clr_wait = 1'b1;
                            n_phase        = PH_WAIT_START;
                        end else if (r_phase == PH_SENDING) begin
                            if (i_stat.pos_lt_len) begin
                                o_cmd.read_byte = 1'b1;
                                n_state         = S_READ;
                            end
                            if (!i_stat.pos_lt_len || i_stat.pos_at_end) begin
                                o_cmd.clr_wait = 1'b1;
                                n_phase        = PH_WAIT_MSG;
                            end
                        end
                    end
                    ACT_RX_BYTE: begin
                        if (r_rx_error) begin
                            o_cmd.set_error = 1'b1;
                            n_phase         = PH_IDLE;
                        end else if (r_phase == PH_WAIT_START) begin
                            if (!i_stat.ack_match) begin
                                o_cmd.set_error = 1'b1;
                                n_phase         = PH_IDLE;
                            end else if (!i_stat.queue_busy) begin
                                n_phase = PH_IDLE;
                            end else begin
                                // length of the new slot is read in S_LEN
                                o_cmd.dequeue = 1'b1;
                                n_phase       = PH_SENDING;
                                n_state       = S_LEN;
                            end
                        end else if (r_phase == PH_WAIT_MSG) begin
                            o_cmd.set_error = ~i_stat.ack_match;
                            n_phase         = PH_IDLE;
                        end
                    end
                    ACT_TICK: begin
                        if (r_phase == PH_WAIT_START || r_phase == PH_WAIT_MSG) begin
                            if (i_stat.tick_expired) begin
                                n_phase = PH_IDLE;
                            end else begin
                                o_cmd.count_tick = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_TERM: begin
                o_cmd.commit   = 1'b1;
                o_cmd.clr_fill = 1'b1;
                n_state        = S_DONE;
            end
            S_LEN: begin
                n_state = S_DONE;
            end
            S_READ: begin
                o_cmd.load_byte = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
            r_action    <= ACT_ENQUEUE;
            r_last      <= 1'b0;
            r_rx_error  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (accept) begin
                r_action   <= t_action'(i_action);
                r_last     <= i_last;
                r_rx_error <= i_rx_error;
                r_in_ready <= 1'b0;
            end else if (o_cmd.load_out) begin
                r_in_ready <= 1'b1;
            end
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = r_in_ready;
    assign o_m_tvalid = r_out_valid;

endmodule

// File: rtl/core/amus_checker.sv
// ----------------------------------------------------------------------------
// amus_checker
// Port-level checks of the message sender, bound to the top level.
// ----------------------------------------------------------------------------
module amus_checker #(
    parameter int MSG_SLOTS = 64,
    parameter int OUT_W     = 24
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    localparam int CW = $clog2(MSG_SLOTS + 1);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped or changed while stalled");

    // one request in flight: ready drops after each acceptance
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in flight");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[amus_pkg::OUT_FIXED_W +: CW] <= CW'(MSG_SLOTS))
        else $error("queue count above slot count");

    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[8:1] == 8'h00)
        else $error("tx byte nonzero without tx valid");

    a_accept_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[9] |-> !o_m_tdata[0])
        else $error("commit and transmit in one result");

endmodule

bind acked_message_uart_sender amus_checker #(
    .MSG_SLOTS (MSG_SLOTS),
    .OUT_W     (OUT_W)
) u_amus_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
